>>> rtl/thermal_frame_upscale_minmax_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the thermal frame upscaler
// Shared concurrent assertion forms; each expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef THERMAL_FRAME_UPSCALE_MINMAX_DEFINES_SVH
`define THERMAL_FRAME_UPSCALE_MINMAX_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFUM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TFUM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tfum_pkg.sv
// ---------------------------------------------------------------------------
// Thermal frame upscaler package
// Fixed field widths, the floor start value and the frame position record.
// ---------------------------------------------------------------------------
package tfum_pkg;

  localparam int PIX_W   = 12;
  localparam int FLOOR_W = 11;
  localparam int IDX_W   = 6;

  localparam logic [FLOOR_W-1:0] FLOOR_START = 11'h7FF;

  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [FLOOR_W-1:0] floor_t;
  typedef logic [IDX_W-1:0]   idx_t;

  typedef struct packed {
    logic first;
    logic last;
    logic h_ok;
    logic v_ok;
    idx_t idx;
  } pos_info_t;

endpackage

>>> rtl/tfum_in_stage.sv
// ---------------------------------------------------------------------------
// Thermal frame upscaler input register
// Holds one input transaction ahead of the processing stage.
// ---------------------------------------------------------------------------
module tfum_in_stage
  import tfum_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  pix_t in_pixel,
  input  logic in_frame_restart,
  input  logic adv,
  output logic s1_valid,
  output pix_t s1_pixel,
  output logic s1_restart
);

  logic valid_r;
  pix_t pixel_r;
  logic restart_r;
  logic load;

  assign load     = !valid_r || adv;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      pixel_r   <= in_pixel;
      restart_r <= in_frame_restart;
    end
  end

  assign s1_valid   = valid_r;
  assign s1_pixel   = pixel_r;
  assign s1_restart = restart_r;

endmodule

>>> rtl/tfum_pos_track.sv
// ---------------------------------------------------------------------------
// Thermal frame upscaler position tracker
// Row, column and index counters for the pixel in the processing stage.
// ---------------------------------------------------------------------------
module tfum_pos_track
  import tfum_pkg::*;
#(
  parameter int FRAME_COLS = 8,
  parameter int FRAME_ROWS = 8,
  localparam int CW = $clog2(FRAME_COLS),
  localparam int RW = $clog2(FRAME_ROWS)
)
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic          restart,
  output logic [CW-1:0] col_cur,
  output logic [CW-1:0] rd_col,
  output pos_info_t     info
);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt, row_cur;
  idx_t          idx_r, idx_nxt, idx_cur;
  logic          last_col, last_row;

  always_comb begin
    col_cur  = restart ? '0 : col_r;
    row_cur  = restart ? '0 : row_r;
    idx_cur  = restart ? '0 : idx_r;
    last_col = (col_cur == CW'(FRAME_COLS - 1));
    last_row = (row_cur == RW'(FRAME_ROWS - 1));
    col_nxt  = last_col ? '0 : col_cur + CW'(1);
    if (last_col) begin
      row_nxt = last_row ? '0 : row_cur + RW'(1);
    end else begin
      row_nxt = row_cur;
    end
    idx_nxt    = (last_col && last_row) ? '0 : idx_cur + IDX_W'(1);
    info.first = (col_cur == '0) && (row_cur == '0);
    info.last  = last_col && last_row;
    info.h_ok  = (col_cur != '0);
    info.v_ok  = (row_cur != '0);
    info.idx   = idx_cur;
    rd_col     = fire ? col_nxt : col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      idx_r <= '0;
    end else if (fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

>>> rtl/tfum_interp.sv
// ---------------------------------------------------------------------------
// Thermal frame upscaler datapath
// Line buffer, neighbor averages, frame extremes and the result register.
// ---------------------------------------------------------------------------
module tfum_interp
  import tfum_pkg::*;
#(
  parameter int FRAME_COLS = 8,
  localparam int CW = $clog2(FRAME_COLS)
)
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s1_valid,
  input  pix_t          s1_pixel,
  input  logic [CW-1:0] col_cur,
  input  logic [CW-1:0] rd_col,
  input  pos_info_t     info,
  input  logic          out_stall,
  output logic          adv,
  output logic          fire,
  output logic          out_valid,
  output pix_t          out_horiz_avg,
  output logic          out_horiz_ok,
  output pix_t          out_vert_avg,
  output logic          out_vert_ok,
  output pix_t          out_diag_avg,
  output logic          out_diag_ok,
  output logic          out_frame_done,
  output pix_t          out_peak_value,
  output idx_t          out_peak_index,
  output floor_t        out_floor_value,
  output idx_t          out_floor_index
);

`include "thermal_frame_upscale_minmax_defines.svh"

  pix_t   row_mem [FRAME_COLS];
  pix_t   above_r;
  pix_t   left_r;
  pix_t   upleft_r;
  pix_t   peak_r, peak_nxt, peak_base;
  idx_t   peak_pos_r, peak_pos_nxt, peak_pos_base;
  floor_t floor_r, floor_nxt, floor_base;
  idx_t   floor_pos_r, floor_pos_nxt, floor_pos_base;
  logic   d_ok;
  logic [PIX_W:0] h_sum, v_sum, d_sum;

  logic   valid_r;
  pix_t   h_avg_r, v_avg_r, d_avg_r;
  logic   h_ok_r, v_ok_r, d_ok_r, done_r;
  pix_t   peak_out_r;
  idx_t   peak_idx_r;
  floor_t floor_out_r;
  idx_t   floor_idx_r;

  assign adv  = !valid_r || !out_stall;
  assign fire = s1_valid && adv;
  assign d_ok = info.h_ok && info.v_ok;

  always_ff @(posedge clk) begin
    if (fire) begin
      row_mem[col_cur] <= s1_pixel;
    end
    above_r <= row_mem[rd_col];
  end

  always_comb begin
    h_sum = {1'b0, s1_pixel} + {1'b0, left_r};
    v_sum = {1'b0, s1_pixel} + {1'b0, above_r};
    d_sum = {1'b0, s1_pixel} + {1'b0, upleft_r};

    if (info.first) begin
      peak_base      = '0;
      peak_pos_base  = '0;
      floor_base     = FLOOR_START;
      floor_pos_base = '0;
    end else begin
      peak_base      = peak_r;
      peak_pos_base  = peak_pos_r;
      floor_base     = floor_r;
      floor_pos_base = floor_pos_r;
    end

    peak_nxt      = peak_base;
    peak_pos_nxt  = peak_pos_base;
    floor_nxt     = floor_base;
    floor_pos_nxt = floor_pos_base;
    if (s1_pixel > peak_base) begin
      peak_nxt     = s1_pixel;
      peak_pos_nxt = info.idx;
    end
    if (s1_pixel < {1'b0, floor_base}) begin
      floor_nxt     = s1_pixel[FLOOR_W-1:0];
      floor_pos_nxt = info.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r      <= '0;
      peak_pos_r  <= '0;
      floor_r     <= FLOOR_START;
      floor_pos_r <= '0;
    end else if (fire) begin
      peak_r      <= peak_nxt;
      peak_pos_r  <= peak_pos_nxt;
      floor_r     <= floor_nxt;
      floor_pos_r <= floor_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      left_r   <= s1_pixel;
      upleft_r <= above_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      h_avg_r     <= info.h_ok ? h_sum[PIX_W:1] : '0;
      v_avg_r     <= info.v_ok ? v_sum[PIX_W:1] : '0;
      d_avg_r     <= d_ok ? d_sum[PIX_W:1] : '0;
      h_ok_r      <= info.h_ok;
      v_ok_r      <= info.v_ok;
      d_ok_r      <= d_ok;
      done_r      <= info.last;
      peak_out_r  <= info.last ? peak_nxt : '0;
      peak_idx_r  <= info.last ? peak_pos_nxt : '0;
      floor_out_r <= info.last ? floor_nxt : '0;
      floor_idx_r <= info.last ? floor_pos_nxt : '0;
    end
  end

  assign out_valid       = valid_r;
  assign out_horiz_avg   = h_avg_r;
  assign out_horiz_ok    = h_ok_r;
  assign out_vert_avg    = v_avg_r;
  assign out_vert_ok     = v_ok_r;
  assign out_diag_avg    = d_avg_r;
  assign out_diag_ok     = d_ok_r;
  assign out_frame_done  = done_r;
  assign out_peak_value  = peak_out_r;
  assign out_peak_index  = peak_idx_r;
  assign out_floor_value = floor_out_r;
  assign out_floor_index = floor_idx_r;

  `TFUM_ASSERT_NOW(a_done_has_neighbors, valid_r && done_r, h_ok_r && v_ok_r && d_ok_r, "last pixel lacks neighbors")
  `TFUM_ASSERT_NOW(a_no_left_zero_avg, valid_r && !h_ok_r, h_avg_r == '0, "horizontal average not cleared")
  `TFUM_ASSERT_NOW(a_extremes_only_at_end, valid_r && !done_r, (peak_out_r == '0) && (floor_out_r == '0), "extremes shown before frame end")
  `TFUM_ASSERT_NEXT(a_fire_gives_result, fire, valid_r, "processed transaction produced no result")

endmodule

>>> rtl/thermal_frame_upscale_minmax.sv
// ---------------------------------------------------------------------------
// Thermal frame upscaler with frame extremes
// Top level: input register, position tracker and interpolation datapath.
// ---------------------------------------------------------------------------
// The block takes one pixel transaction per clock while out_stall is low
// and returns one result transaction per pixel through the input register and
// then the result register, with the line buffer read, the three averages
// and the extreme compares between them. The sustained rate of one
// transaction per clock is set by the line buffer of FRAME_COLS pixels,
// which takes up to one write and one registered read each cycle. While a
// finished result waits under stall, the input register takes one more
// transaction if it is empty and then holds in_stall high until the result
// is taken. The line buffer needs no clearing after reset, since it is read
// only for rows already written in the current frame.
module thermal_frame_upscale_minmax
  import tfum_pkg::*;
#(
  parameter int FRAME_COLS = 8,
  parameter int FRAME_ROWS = 8
)
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  pix_t   in_pixel,
  input  logic   in_frame_restart,
  output logic   out_valid,
  input  logic   out_stall,
  output pix_t   out_horiz_avg,
  output logic   out_horiz_ok,
  output pix_t   out_vert_avg,
  output logic   out_vert_ok,
  output pix_t   out_diag_avg,
  output logic   out_diag_ok,
  output logic   out_frame_done,
  output pix_t   out_peak_value,
  output idx_t   out_peak_index,
  output floor_t out_floor_value,
  output idx_t   out_floor_index
);

  localparam int CW = $clog2(FRAME_COLS);

  logic          adv;
  logic          fire;
  logic          s1_valid;
  pix_t          s1_pixel;
  logic          s1_restart;
  logic [CW-1:0] col_cur;
  logic [CW-1:0] rd_col;
  pos_info_t     info;

  tfum_in_stage u_in_stage (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel         (in_pixel),
    .in_frame_restart (in_frame_restart),
    .adv              (adv),
    .s1_valid         (s1_valid),
    .s1_pixel         (s1_pixel),
    .s1_restart       (s1_restart)
  );

  tfum_pos_track #(
    .FRAME_COLS (FRAME_COLS),
    .FRAME_ROWS (FRAME_ROWS)
  ) u_pos_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .restart (s1_restart),
    .col_cur (col_cur),
    .rd_col  (rd_col),
    .info    (info)
  );

  tfum_interp #(
    .FRAME_COLS (FRAME_COLS)
  ) u_interp (
    .clk             (clk),
    .rst_n           (rst_n),
    .s1_valid        (s1_valid),
    .s1_pixel        (s1_pixel),
    .col_cur         (col_cur),
    .rd_col          (rd_col),
    .info            (info),
    .out_stall       (out_stall),
    .adv             (adv),
    .fire            (fire),
    .out_valid       (out_valid),
    .out_horiz_avg   (out_horiz_avg),
    .out_horiz_ok    (out_horiz_ok),
    .out_vert_avg    (out_vert_avg),
    .out_vert_ok     (out_vert_ok),
    .out_diag_avg    (out_diag_avg),
    .out_diag_ok     (out_diag_ok),
    .out_frame_done  (out_frame_done),
    .out_peak_value  (out_peak_value),
    .out_peak_index  (out_peak_index),
    .out_floor_value (out_floor_value),
    .out_floor_index (out_floor_index)
  );

endmodule
